// File: hw/rtl/rmeul_pkg.sv
`default_nettype none
package rmeul_pkg;

    localparam int DataW       = 16;
    localparam int MagW        = 15;
    localparam int CordicDef   = 16;
    localparam int AtanTabLen  = 24;
    // cordic datapath: |v| <= 2^15 scaled by 2^16, growth below 2x
    localparam int CxW         = 35;
    localparam int ZW          = 34;
    localparam int SqW         = 29;
    localparam int RootW       = 15;

    localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
    localparam logic signed [15:0]   PiQ13     = 16'sd25736;
    localparam logic signed [15:0]   HalfPiQ13 = 16'sd12868;
    localparam logic signed [DataW-1:0] OneQ14 = 16'sd16384;

    localparam logic [1:0] RegMinMag = 2'd0;

    // arctangent of 2^-i in q2.30
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 34'sd843314856;
            1: r = 34'sd497837829;
            2: r = 34'sd263043836;
            3: r = 34'sd133525158;
            4: r = 34'sd67021686;
            5: r = 34'sd33543515;
            6: r = 34'sd16775850;
            7: r = 34'sd8388437;
            8: r = 34'sd4194282;
            9: r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q2.30 to q3.13, round half away from zero, clamp
    function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [15:0] lim);
        logic [ZW-1:0] m;
        logic [ZW-1:0] q;
        logic signed [ZW-1:0] r;
        m = a[ZW-1] ? ZW'(-a) : ZW'(a);
        q = (m + ZW'(65536)) >> 17;
        r = a[ZW-1] ? -$signed(q) : $signed(q);
        if (r > ZW'(lim))
            r = ZW'(lim);
        if (r < -ZW'(lim))
            r = -ZW'(lim);
        return r[15:0];
    endfunction

    typedef struct packed {
        logic signed [CxW-1:0] x;
        logic signed [CxW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  zero;
    } cvec_t;

endpackage
`default_nettype wire

// File: hw/rtl/rmeul_isqrt.sv
`default_nettype none
// pipelined square root of 2^28 - m02^2, one result bit per stage
module rmeul_isqrt
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [rmeul_pkg::SqW-1:0] val,
    output logic [rmeul_pkg::RootW-1:0] root
);
    import rmeul_pkg::*;

    localparam int N = RootW;

    logic [SqW-1:0] rem_reg [N+1];
    logic [RootW-1:0] res_reg [N+1];

    assign rem_reg[0] = val;
    assign res_reg[0] = '0;

    // restoring square root, msb first
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_st
            localparam int B = N - 1 - g;
            logic [RootW-1:0] trial;
            logic [SqW+1:0] sq;
            always_comb
            begin
                trial = res_reg[g] | (RootW'(1) << B);
                sq = (SqW+2)'(trial) * (SqW+2)'(trial);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= rem_reg[g];
                    res_reg[g+1] <= (sq <= (SqW+2)'(rem_reg[g])) ? trial : res_reg[g];
                end
            end
        end
    endgenerate

    assign root = res_reg[N];
endmodule
`default_nettype wire

// File: hw/rtl/rmeul_cordic.sv
`default_nettype none
// pipelined vectoring cordic, one micro-rotation per stage
module rmeul_cordic #(
    parameter int STEPS = rmeul_pkg::CordicDef
)
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic signed [16:0] y_in,
    input  wire logic signed [16:0] x_in,
    output logic signed [rmeul_pkg::ZW-1:0] angle
);
    import rmeul_pkg::*;

    localparam int S = (STEPS > AtanTabLen) ? AtanTabLen : STEPS;

    cvec_t st_reg [S+1];
    logic signed [16:0] xn, yn;
    logic signed [ZW-1:0] z0;

    // quadrant fold
    always_comb
    begin
        xn = x_in;
        yn = y_in;
        z0 = '0;
        if (x_in < 0)
        begin
            z0 = (y_in > 0) ? PiQ30 : -PiQ30;
            xn = -x_in;
            yn = -y_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].x    <= CxW'(xn) <<< 16;
            st_reg[0].y    <= CxW'(yn) <<< 16;
            st_reg[0].z    <= (y_in == 0) ? ((x_in < 0) ? PiQ30 : '0) : z0;
            st_reg[0].zero <= (y_in == 0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < S; g++)
        begin : g_st
            logic signed [CxW-1:0] xs, ys;
            assign xs = st_reg[g].x >>> g;
            assign ys = st_reg[g].y >>> g;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[g+1].zero <= st_reg[g].zero;
                    if (st_reg[g].zero)
                    begin
                        st_reg[g+1].x <= st_reg[g].x;
                        st_reg[g+1].y <= st_reg[g].y;
                        st_reg[g+1].z <= st_reg[g].z;
                    end
                    else if (st_reg[g].y < 0)
                    begin
                        st_reg[g+1].x <= st_reg[g].x - ys;
                        st_reg[g+1].y <= st_reg[g].y + xs;
                        st_reg[g+1].z <= st_reg[g].z - atan_q30(g);
                    end
                    else
                    begin
                        st_reg[g+1].x <= st_reg[g].x + ys;
                        st_reg[g+1].y <= st_reg[g].y - xs;
                        st_reg[g+1].z <= st_reg[g].z + atan_q30(g);
                    end
                end
            end
        end
    endgenerate

    assign angle = st_reg[S].z;
endmodule
`default_nettype wire

// File: hw/rtl/rotation_matrix_to_euler_xyz.sv
// path: input register, square root stages, cordic input register, cordic stages, output register (steps capped at 24)
// throughput: one matrix per cycle; pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage
// reset: rst_n async active low clears valid bits; min_magnitude resets to 1
// depth is set by the square root stages followed by the cordic stages
`default_nettype none
module rotation_matrix_to_euler_xyz #(
    parameter int CORDIC_STEPS = rmeul_pkg::CordicDef
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // m00, m01, m02, m12, m22
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // roll[15:0], pitch[30:16], yaw[46:31], valid_res[47]
    output logic [47:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rmeul_pkg::*;

    localparam int CS = (CORDIC_STEPS > AtanTabLen) ? AtanTabLen : CORDIC_STEPS;
    localparam int LAT = 1 + RootW + 1 + CS + 1;

    logic [MagW-1:0] min_mag_reg;
    logic en;
    logic [LAT-1:0] vld_reg;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == RegMinMag) ? 32'(min_mag_reg) : '0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_mag_reg <= MagW'(1);
        else if (psel && penable && pwrite && paddr == RegMinMag)
            min_mag_reg <= pwdata[MagW-1:0];
    end

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // input unpack and stage 0
    logic signed [15:0] m00, m01, m02, m12, m22;
    assign m00 = s_axis_tdata[15:0];
    assign m01 = s_axis_tdata[31:16];
    assign m02 = s_axis_tdata[47:32];
    assign m12 = s_axis_tdata[63:48];
    assign m22 = s_axis_tdata[79:64];

    logic [16:0] a00, a22, a02;
    assign a00 = m00[15] ? 17'(-$signed({m00[15], m00})) : 17'(m00);
    assign a22 = m22[15] ? 17'(-$signed({m22[15], m22})) : 17'(m22);
    assign a02 = m02[15] ? 17'(-$signed({m02[15], m02})) : 17'(m02);

    logic signed [16:0] r0y_reg, r0x_reg, y0y_reg, y0x_reg, m02_reg;
    logic [SqW-1:0] sq_reg;
    logic ok_reg, sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0y_reg <= -17'(m12);
            r0x_reg <= 17'(m22);
            y0y_reg <= -17'(m01);
            y0x_reg <= 17'(m00);
            m02_reg <= 17'(m02);
            sq_reg  <= (a02 >= 17'(OneQ14)) ? '0 :
                       SqW'(29'd268435456 - 29'(a02[13:0]) * 29'(a02[13:0]));
            ok_reg  <= (a00 >= 17'(min_mag_reg)) && (a22 >= 17'(min_mag_reg));
            sat_reg <= (a02 >= 17'(OneQ14));
        end
    end

    // square root stages, other operands delayed alongside
    logic [RootW-1:0] root;
    rmeul_isqrt u_sqrt (.clk(clk), .en(en), .val(sq_reg), .root(root));

    localparam int DD = RootW + 1;
    logic signed [16:0] d_ry [DD], d_rx [DD], d_yy [DD], d_yx [DD], d_m02 [DD];
    logic d_ok [DD], d_sat [DD];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ry[0] <= r0y_reg; d_rx[0] <= r0x_reg;
            d_yy[0] <= y0y_reg; d_yx[0] <= y0x_reg;
            d_m02[0] <= m02_reg; d_ok[0] <= ok_reg; d_sat[0] <= sat_reg;
            for (int i = 1; i < DD; i++)
            begin
                d_ry[i] <= d_ry[i-1]; d_rx[i] <= d_rx[i-1];
                d_yy[i] <= d_yy[i-1]; d_yx[i] <= d_yx[i-1];
                d_m02[i] <= d_m02[i-1]; d_ok[i] <= d_ok[i-1]; d_sat[i] <= d_sat[i-1];
            end
        end
    end

    // three cordic lanes
    logic signed [ZW-1:0] ang_r, ang_p, ang_y;
    rmeul_cordic #(.STEPS(CORDIC_STEPS)) u_roll (.clk(clk), .en(en),
        .y_in(d_ry[DD-2]), .x_in(d_rx[DD-2]), .angle(ang_r));
    rmeul_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (.clk(clk), .en(en),
        .y_in(d_m02[DD-2]), .x_in(17'(root)), .angle(ang_p));
    rmeul_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (.clk(clk), .en(en),
        .y_in(d_yy[DD-2]), .x_in(d_yx[DD-2]), .angle(ang_y));

    logic c_ok [CS+1], c_sat [CS+1], c_neg [CS+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ok[0] <= d_ok[DD-2]; c_sat[0] <= d_sat[DD-2]; c_neg[0] <= d_m02[DD-2][16];
            for (int i = 1; i <= CS; i++)
            begin
                c_ok[i] <= c_ok[i-1]; c_sat[i] <= c_sat[i-1]; c_neg[i] <= c_neg[i-1];
            end
        end
    end

    // output register
    logic signed [15:0] roll_reg, yaw_reg, pitch_w;
    logic signed [14:0] pitch_reg;
    logic vres_reg;
    always_comb
    begin
        if (c_sat[CS])
            pitch_w = c_neg[CS] ? -HalfPiQ13 : HalfPiQ13;
        else
            pitch_w = to_q13(ang_p, HalfPiQ13);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vres_reg  <= c_ok[CS];
            roll_reg  <= c_ok[CS] ? to_q13(ang_r, PiQ13) : '0;
            yaw_reg   <= c_ok[CS] ? to_q13(ang_y, PiQ13) : '0;
            pitch_reg <= c_ok[CS] ? pitch_w[14:0] : '0;
        end
    end

    assign m_axis_tdata = {vres_reg, yaw_reg, pitch_reg, roll_reg};

    logic unused;
    assign unused = ^{d_ry[DD-1], d_rx[DD-1], d_yy[DD-1], d_yx[DD-1], d_m02[DD-1],
                      d_ok[DD-1], d_sat[DD-1], pwdata[31:MagW]};
endmodule
`default_nettype wire

// File: hw/rtl/rmeul_checker.sv
`default_nettype none
module rmeul_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    // output held under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // invalid result carries zero angles
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[47] |-> m_axis_tdata[46:0] == '0)
        else $error("invalid word with nonzero angles");
    // ready follows output room
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind rotation_matrix_to_euler_xyz rmeul_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
`default_nettype wire
